// ===== rtl/hmtp_pkg.sv =====
// ----------------------------------------------------------------------------
// hmtp_pkg
// Types, constants and character helpers for the height map token parser.
// ----------------------------------------------------------------------------
package hmtp_pkg;

  localparam int MAX_COLUMNS = 4096;
  localparam int MAX_ROWS    = 4096;
  localparam int COL_W       = $clog2(MAX_COLUMNS);
  localparam int ROW_W       = $clog2(MAX_ROWS);
  localparam int COORD_W     = 12;
  localparam int COLOR_W     = 24;
  localparam int ALT_W       = 32;

  localparam logic [ALT_W-1:0]   MAG_LIMIT   = 32'h8000_0000;
  localparam logic [ALT_W-1:0]   ALT_MAX     = 32'h7FFF_FFFF;
  localparam logic [COLOR_W-1:0] COLOR_RESET = 24'hFF_FFFF;

  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  localparam logic [2:0] PH_BETWEEN = 3'd0;
  localparam logic [2:0] PH_TOKEN   = 3'd1;
  localparam logic [2:0] PH_COMMA   = 3'd2;
  localparam logic [2:0] PH_ZERO    = 3'd3;
  localparam logic [2:0] PH_HEX     = 3'd4;
  localparam logic [2:0] PH_DEAD    = 3'd5;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [COORD_W-1:0]      point_column;
    logic [COORD_W-1:0]      point_row;
    logic signed [ALT_W-1:0] altitude;
    logic [COLOR_W-1:0]      point_color;
  } out_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  // bit 4 flags a valid hex digit, low nibble is its value
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    if ((c >= 8'h30) && (c <= 8'h39)) begin
      d = c - 8'h30;
      return {1'b1, d[3:0]};
    end else if ((c >= 8'h61) && (c <= 8'h66)) begin
      d = c - 8'h57;
      return {1'b1, d[3:0]};
    end else if ((c >= 8'h41) && (c <= 8'h46)) begin
      d = c - 8'h37;
      return {1'b1, d[3:0]};
    end
    return 5'd0;
  endfunction

endpackage

// ===== rtl/height_map_token_parser_core.sv =====
// A point is registered into the output queue when its closing byte is accepted.
// One byte per cycle unless the queue is full; parse state is one register stage.
// A two-entry output queue lets input continue while one point waits.
// Reset (synchronous, rst_n low): parser between tokens, row and column zero,
// queue empty, default color all ones.
// ----------------------------------------------------------------------------
// height_map_token_parser_core
// Parses a text height map byte stream into column, row, altitude and color.
// ----------------------------------------------------------------------------
module height_map_token_parser_core
  import hmtp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  in_t                in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output out_t               out_data,
  input  logic               cfg_wr_en,
  input  logic [COLOR_W-1:0] cfg_wr_data
);

  logic [2:0]         phase_r, phase_nxt;
  logic               neg_r, neg_nxt;
  logic [ALT_W-1:0]   acc_r, acc_nxt;
  logic               closed_r, closed_nxt;
  logic [COLOR_W-1:0] color_r, color_nxt;
  logic               found_r, found_nxt;
  logic [COL_W-1:0]   col_r, col_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic [COLOR_W-1:0] dflt_color_r;

  logic               out_valid_r, skid_valid_r;
  out_t               out_r, skid_r;

  logic               accept, emit, push, pop;
  logic [7:0]         c;
  logic               start;
  logic [2:0]         ph_b;
  logic [ALT_W-1:0]   acc_b;
  logic               closed_b;
  logic [COLOR_W-1:0] color_b;
  logic [ALT_W+2:0]   prod;
  logic [4:0]         hv;
  logic [ALT_W-1:0]   alt;
  out_t               point;

  assign accept = in_valid && in_ready;
  assign in_ready = !skid_valid_r;
  assign c = in_data.char_byte;
  assign hv = hex_value(c);
  assign start = (phase_r == PH_BETWEEN);

  always_comb begin
    phase_nxt  = phase_r;
    neg_nxt    = neg_r;
    acc_nxt    = acc_r;
    closed_nxt = closed_r;
    color_nxt  = color_r;
    found_nxt  = found_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    emit       = 1'b0;
    ph_b       = start ? PH_TOKEN : phase_r;
    acc_b      = start ? '0 : acc_r;
    closed_b   = start ? 1'b0 : closed_r;
    color_b    = start ? '0 : color_r;
    prod = ({3'b000, acc_b} << 3) + ({3'b000, acc_b} << 1)
         + {31'd0, c[3:0] - 4'h0};

    if (!is_space(c)) begin
      if (start) begin
        neg_nxt   = (c == CH_MINUS);
        found_nxt = 1'b0;
      end
      acc_nxt    = acc_b;
      closed_nxt = closed_b;
      color_nxt  = color_b;
      phase_nxt  = ph_b;
      if (!(start && ((c == CH_PLUS) || (c == CH_MINUS)))) begin
        if (!closed_b && is_digit(c)) begin
          acc_nxt = (prod > {3'b000, MAG_LIMIT}) ? MAG_LIMIT : prod[ALT_W-1:0];
        end else begin
          closed_nxt = 1'b1;
        end
      end
      unique case (ph_b)
        PH_TOKEN: begin
          if (c == CH_COMMA) phase_nxt = PH_COMMA;
        end
        PH_COMMA: phase_nxt = (c == CH_ZERO) ? PH_ZERO : PH_DEAD;
        PH_ZERO: begin
          if (c == CH_X) begin
            phase_nxt = PH_HEX;
            found_nxt = 1'b1;
            color_nxt = '0;
          end else begin
            phase_nxt = PH_DEAD;
          end
        end
        PH_HEX: begin
          if (hv[4]) color_nxt = {color_b[COLOR_W-5:0], hv[3:0]};
          else       phase_nxt = PH_DEAD;
        end
        default: phase_nxt = PH_DEAD;
      endcase
      emit = in_data.last_byte;
    end else begin
      emit = !start;
    end

    if (emit) begin
      phase_nxt = PH_BETWEEN;
      if (col_r < COL_W'(MAX_COLUMNS - 1)) col_nxt = col_r + 1'b1;
    end
    if (c == CH_LF) begin
      col_nxt = '0;
      if (row_r < ROW_W'(MAX_ROWS - 1)) row_nxt = row_r + 1'b1;
    end
    if (in_data.last_byte) begin
      phase_nxt = PH_BETWEEN;
      col_nxt   = '0;
      row_nxt   = '0;
    end
  end

  always_comb begin
    if (neg_nxt)          alt = '0 - acc_nxt;
    else if (acc_nxt[31]) alt = ALT_MAX;
    else                  alt = acc_nxt;
    point.point_column = COORD_W'(col_r);
    point.point_row    = COORD_W'(row_r);
    point.altitude     = $signed(alt);
    point.point_color  = found_nxt ? color_nxt : dflt_color_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_BETWEEN;
      neg_r        <= 1'b0;
      acc_r        <= '0;
      closed_r     <= 1'b0;
      color_r      <= '0;
      found_r      <= 1'b0;
      col_r        <= '0;
      row_r        <= '0;
      dflt_color_r <= COLOR_RESET;
    end else begin
      if (accept) begin
        phase_r  <= phase_nxt;
        neg_r    <= neg_nxt;
        acc_r    <= acc_nxt;
        closed_r <= closed_nxt;
        color_r  <= color_nxt;
        found_r  <= found_nxt;
        col_r    <= col_nxt;
        row_r    <= row_nxt;
      end
      if (cfg_wr_en) dflt_color_r <= cfg_wr_data;
    end
  end

  assign push = accept && emit;
  assign pop  = out_valid_r && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (skid_valid_r) begin
        if (pop) begin
          out_r        <= skid_r;
          skid_valid_r <= 1'b0;
        end
      end else if (out_valid_r) begin
        if (push && pop) begin
          out_r <= point;
        end else if (push) begin
          skid_r       <= point;
          skid_valid_r <= 1'b1;
        end else if (pop) begin
          out_valid_r <= 1'b0;
        end
      end else if (push) begin
        out_r       <= point;
        out_valid_r <= 1'b1;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held without head entry");

  a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_data.last_byte) |=>
      (phase_r == PH_BETWEEN) && (col_r == '0) && (row_r == '0))
    else $error("final byte did not restart the map");

  a_acc_limit: assert property (@(posedge clk) disable iff (!rst_n)
    acc_r <= MAG_LIMIT)
    else $error("altitude magnitude beyond saturation limit");

  a_newline_col: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_data.char_byte == CH_LF)) |=> (col_r == '0))
    else $error("newline did not clear the column");

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Height map parser: drives text bytes with random gaps and back-pressure and
// checks every emitted point against a cycle-free parse of the same stream.
// ----------------------------------------------------------------------------
module tb_top;
  import hmtp_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;

  logic               clk         = 1'b0;
  logic               rst_n       = 1'b0;
  logic               in_valid    = 1'b0;
  logic               in_ready;
  in_t                in_data     = '0;
  logic               out_valid;
  logic               out_ready   = 1'b0;
  out_t               out_data;
  logic               cfg_wr_en   = 1'b0;
  logic [COLOR_W-1:0] cfg_wr_data = '0;

  height_map_token_parser_core uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #1 clk = ~clk;

  in_t        byte_q[$];
  out_t       pending_points[$];
  logic [7:0] tok_buf[$];
  string      hex_digits = "0123456789abcdefABCDEF";
  int         items_queued = 0;
  int         err_cnt = 0;

  // parser shadow state
  logic [2:0]         ph;
  logic               neg;
  logic [ALT_W-1:0]   mag;
  logic               closed;
  logic [COLOR_W-1:0] hue;
  logic               hue_set;
  logic [COORD_W-1:0] col;
  logic [COORD_W-1:0] row;
  logic [COLOR_W-1:0] dflt_color;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic [7:0] rand_inked();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (is_blank(c));
    return c;
  endfunction

  function automatic logic [7:0] rand_blank();
    case ($urandom_range(0, 4))
      0: return 8'h20;
      1: return 8'h09;
      2: return 8'h0B;
      3: return 8'h0C;
      default: return 8'h0D;
    endcase
  endfunction

  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 13);
  endfunction

  task automatic take_digit(input logic [7:0] c);
    logic [35:0] nxt;
    if (!closed && c >= "0" && c <= "9") begin
      nxt = 36'(mag) * 36'd10 + 36'(c - CH_ZERO);
      mag = (nxt > 36'(MAG_LIMIT)) ? MAG_LIMIT : nxt[31:0];
    end else begin
      closed = 1'b1;
    end
  endtask

  task automatic emit_point();
    out_t p;
    p.point_column = col;
    p.point_row    = row;
    if (neg) p.altitude = 32'd0 - mag;
    else p.altitude = (mag > ALT_MAX) ? ALT_MAX : mag;
    p.point_color = hue_set ? hue : dflt_color;
    pending_points.push_back(p);
    if (int'(col) < MAX_COLUMNS - 1) col++;
    ph = PH_BETWEEN;
  endtask

  task automatic parse_byte(input in_t b);
    logic [7:0] c;
    logic [7:0] d;
    logic       hex_ok;
    c = b.char_byte;
    if (!is_blank(c)) begin
      if (ph == PH_BETWEEN) begin
        neg     = 1'b0;
        mag     = '0;
        closed  = 1'b0;
        hue     = '0;
        hue_set = 1'b0;
        ph      = PH_TOKEN;
        if (c == CH_PLUS || c == CH_MINUS) neg = (c == CH_MINUS);
        else take_digit(c);
      end else begin
        take_digit(c);
      end
      case (ph)
        PH_TOKEN: if (c == CH_COMMA) ph = PH_COMMA;
        PH_COMMA: ph = (c == CH_ZERO) ? PH_ZERO : PH_DEAD;
        PH_ZERO: begin
          if (c == CH_X) begin
            ph      = PH_HEX;
            hue_set = 1'b1;
            hue     = '0;
          end else begin
            ph = PH_DEAD;
          end
        end
        PH_HEX: begin
          hex_ok = 1'b1;
          d      = 8'h00;
          if (c >= "0" && c <= "9") d = c - "0";
          else if (c >= "a" && c <= "f") d = c - "a" + 8'd10;
          else if (c >= "A" && c <= "F") d = c - "A" + 8'd10;
          else hex_ok = 1'b0;
          if (hex_ok) hue = {hue[COLOR_W-5:0], d[3:0]};
          else ph = PH_DEAD;
        end
        default: ph = PH_DEAD;
      endcase
      if (b.last_byte) emit_point();
    end else begin
      if (ph != PH_BETWEEN) emit_point();
      if (c == CH_LF) begin
        col = '0;
        if (int'(row) < MAX_ROWS - 1) row++;
      end
    end
    if (b.last_byte) begin
      ph  = PH_BETWEEN;
      col = '0;
      row = '0;
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (want_v !== got_v) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want_v, got_v);
    end
  endtask

  // ---------------- driver ----------------
  int in_wait = 0;
  int in_calm = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_wait = 0;
    end else if (!(in_valid && !in_ready)) begin
      if (in_wait != 0) begin
        in_wait--;
        in_valid <= 1'b0;
      end else if (byte_q.size() != 0) begin
        in_data  <= byte_q.pop_front();
        in_valid <= 1'b1;
        in_wait = draw_wait(in_calm);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------- monitor ----------------
  int   out_wait = 0;
  int   out_calm = 0;
  int   quiet = 0;
  out_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      ph         = PH_BETWEEN;
      neg        = 1'b0;
      mag        = '0;
      closed     = 1'b0;
      hue        = '0;
      hue_set    = 1'b0;
      col        = '0;
      row        = '0;
      dflt_color = COLOR_RESET;
      out_ready <= 1'b0;
      out_wait = 0;
      quiet = 0;
    end else begin
      quiet++;
      if (cfg_wr_en) begin
        dflt_color = cfg_wr_data;
        quiet = 0;
      end
      if (in_valid && in_ready) begin
        parse_byte(in_data);
        quiet = 0;
      end
      if (out_valid && out_ready) begin
        quiet = 0;
        if (pending_points.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected transaction, expected none, got %h", $time, out_data);
        end else begin
          want = pending_points.pop_front();
          check_field("point_column", 32'(want.point_column), 32'(out_data.point_column));
          check_field("point_row", 32'(want.point_row), 32'(out_data.point_row));
          check_field("altitude", want.altitude, out_data.altitude);
          check_field("point_color", 32'(want.point_color), 32'(out_data.point_color));
        end
        out_wait = draw_wait(out_calm);
      end
      if (out_wait != 0) begin
        out_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("height_map_token_parser_core regression: fail");
        $finish;
      end
    end
  end

  // ---------------- stimulus ----------------
  task automatic push_byte(input logic [7:0] c, input logic last);
    in_t b;
    b.char_byte = c;
    b.last_byte = last;
    byte_q.push_back(b);
    items_queued++;
  endtask

  task automatic push_text(input string s, input logic last);
    for (int i = 0; i < s.len(); i++) push_byte(s[i], last && (i == s.len() - 1));
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) tok_buf.push_back(s[i]);
  endtask

  task automatic wait_idle();
    while (byte_q.size() != 0 || in_valid || pending_points.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_default_color(input logic [COLOR_W-1:0] v);
    wait_idle();
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  // mostly well-formed maps with random content, some raw noise
  task automatic gen_phase(input int budget);
    int   first;
    int   n;
    int   r;
    int   ntok;
    logic last;
    first = items_queued;
    while (items_queued - first < budget) begin
      if ($urandom_range(0, 9) == 0) begin
        n = $urandom_range(4, 30);
        for (int k = 0; k < n; k++) push_byte(8'($urandom_range(0, 255)), k == n - 1);
      end else begin
        ntok = $urandom_range(1, 12);
        if ($urandom_range(0, 3) == 0) push_byte(rand_blank(), 1'b0);
        for (int k = 0; k < ntok; k++) begin
          tok_buf.delete();
          if ($urandom_range(0, 19) == 0) begin
            repeat ($urandom_range(1, 8)) tok_buf.push_back(rand_inked());
          end else begin
            r = $urandom_range(0, 7);
            if (r < 2) tok_buf.push_back(CH_MINUS);
            else if (r == 2) tok_buf.push_back(CH_PLUS);
            r = $urandom_range(0, 9);
            if (r == 1) begin
              case ($urandom_range(0, 2))
                0: add_text("2147483647");
                1: add_text("2147483648");
                default: add_text("2147483649");
              endcase
            end else if (r != 0) begin
              n = (r == 2) ? $urandom_range(10, 13) : $urandom_range(1, 4);
              repeat (n) tok_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
            end
            if ($urandom_range(0, 5) == 0)
              tok_buf.push_back(($urandom_range(0, 2) == 0) ? CH_PLUS : rand_inked());
            r = $urandom_range(0, 9);
            if (r < 4) begin
              add_text(",0x");
              r = $urandom_range(0, 9);
              n = (r == 0) ? 0 : (r == 1) ? $urandom_range(7, 9) : $urandom_range(1, 6);
              repeat (n) tok_buf.push_back(hex_digits[$urandom_range(0, 21)]);
            end else if (r == 4) begin
              case ($urandom_range(0, 4))
                0: add_text(",0X1");
                1: add_text(",1x2");
                2: add_text(",x3");
                3: add_text(",");
                default: add_text(",0");
              endcase
            end else if (r == 5) begin
              add_text(",,0x12");
            end
            if ($urandom_range(0, 5) == 0) begin
              if ($urandom_range(0, 1) == 0) add_text(",0xAB");
              else tok_buf.push_back(rand_inked());
            end
            if (tok_buf.size() == 0) tok_buf.push_back(rand_inked());
          end
          last = (k == ntok - 1) && ($urandom_range(0, 1) == 1);
          foreach (tok_buf[i]) push_byte(tok_buf[i], last && (i == tok_buf.size() - 1));
          if (k == ntok - 1) begin
            if (!last) push_byte(($urandom_range(0, 1) == 0) ? CH_LF : rand_blank(), 1'b1);
          end else if ($urandom_range(0, 5) == 0) begin
            push_byte(CH_LF, 1'b0);
            if ($urandom_range(0, 3) == 0) push_byte(rand_blank(), 1'b0);
          end else begin
            repeat ($urandom_range(1, 3)) push_byte(rand_blank(), 1'b0);
          end
        end
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // sign, mixed-case color, unfinished color suffix, new row, saturation flushed by last byte
    push_text("+7,0xA1b -5,0 \n99999999999", 1'b1);

    set_default_color(24'h000000);
    gen_phase(110);
    set_default_color(24'hFFFFFF);
    gen_phase(110);
    set_default_color(24'($urandom));
    gen_phase(110);
    set_default_color(24'($urandom));
    gen_phase(110);

    wait_idle();
    repeat (5) @(negedge clk);
    if (err_cnt == 0) begin
      $display("height_map_token_parser_core regression: pass");
    end else begin
      $display("height_map_token_parser_core regression: fail");
    end
    $finish;
  end

endmodule
